FILE: hw/rtl/brq_pkg.sv
// brq_pkg: shared types and constants for the byte ring queue with delete.
// Command, status and sequencer state codes; default queue depth.
// No dependencies.
package brq_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned BYTE_W    = 8;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_FIND   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_POP,
		ST_SEARCH,
		ST_SHIFT,
		ST_RESULT
	} state_t;

endpackage

FILE: hw/rtl/brq_req_if.sv
// brq_req_if: command channel of the byte ring queue (valid/ready + payload).
// Depends on nothing.
interface brq_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] data_in;

	modport source (output valid, output command, output data_in, input ready);
	modport sink   (input valid, input command, input data_in, output ready);
endinterface

FILE: hw/rtl/brq_rsp_if.sv
// brq_rsp_if: result channel of the byte ring queue (valid/ready + payload).
// OCC_W follows the queue depth; depends on nothing.
interface brq_rsp_if #(
	parameter int unsigned OCC_W = 5
);
	logic             valid;
	logic             ready;
	logic [7:0]       data_out;
	logic [1:0]       status;
	logic [OCC_W-1:0] occupancy;

	modport source (output valid, output data_out, output status, output occupancy,
		input ready);
	modport sink   (input valid, input data_out, input status, input occupancy,
		output ready);
endinterface

FILE: hw/rtl/brq_ram.sv
// brq_ram: generic one-write, one-read RAM with registered read data.
// Width and depth set by parameters; no dependencies.
module brq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/byte_ring_queue_with_delete_core.sv
// byte_ring_queue_with_delete_core: ring queue of bytes with append, remove and
// find-and-delete, run by a small sequencer over one RAM port pair.
// Depends on brq_pkg, brq_req_if, brq_rsp_if and brq_ram.
//
//   channel | dir | payload                          | transfer when
//   --------+-----+----------------------------------+------------------------
//   req     | in  | command[1:0], data_in[7:0]       | req.valid & req.ready
//   rsp     | out | data_out[7:0], status[1:0], occ. | rsp.valid & rsp.ready
//
// Append and unused codes pass through dispatch and result, remove through
// dispatch, pop and result. Find passes through dispatch, scans entries until a
// match or the end, shifts any entries behind a match one place up and ends in
// result; the single read port of the store reads one entry per cycle, with the
// shift writing one entry per cycle behind it.
// One command is in flight at a time; req.ready is high only while idle.
// A finished result sits in the output register until taken, and a new command
// is accepted meanwhile; its result waits in the sequencer if the register is
// still full. Reset clears indices, count and control; the store is not cleared.
module byte_ring_queue_with_delete_core
	import brq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF,
	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic      clk,
	input  logic      arst_n,
	brq_req_if.sink   req,
	brq_rsp_if.source rsp
);

	// Ring index helpers: wrap at DEPTH, which need not be a power of two.
	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

	state_t state_q, state_d;

	// Queue bookkeeping
	logic [IDX_W-1:0] head_q, head_d;
	logic [IDX_W-1:0] tail_q, tail_d;
	logic [CNT_W-1:0] count_q, count_d;

	// Command under work
	cmd_t             cmd_q;
	logic [7:0]       data_q;

	// Walk pointer and entries still to scan
	logic [IDX_W-1:0] ptr_q, ptr_d;
	logic [CNT_W-1:0] rem_q, rem_d;

	// Pending result
	logic [7:0]       res_data_q, res_data_d;
	status_t          res_status_q, res_status_d;

	// Output register
	logic             out_valid_q;
	logic [7:0]       out_data_q;
	status_t          out_status_q;
	logic [CNT_W-1:0] out_occ_q;

	// Store ports
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [7:0]       ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic [7:0]       ram_rdata;

	logic             req_xfer;
	logic             rsp_xfer;
	logic             out_free;
	logic             full;
	logic [IDX_W-1:0] ptr_nxt;

	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign rsp_xfer  = out_valid_q && rsp.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign ptr_nxt   = next_idx(ptr_q);

	brq_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer: next state, bookkeeping updates and store accesses.
	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		tail_d       = tail_q;
		count_d      = count_q;
		ptr_d        = ptr_q;
		rem_d        = rem_q;
		res_data_d   = res_data_q;
		res_status_d = res_status_q;
		ram_we       = 1'b0;
		ram_waddr    = tail_q;
		ram_wdata    = data_q;
		ram_raddr    = head_q;

		case (state_q)
			ST_IDLE: begin
				if (req_xfer) begin
					state_d = ST_DISPATCH;
				end
			end

			ST_DISPATCH: begin
				// Head is read this cycle for remove and find.
				res_data_d   = '0;
				res_status_d = STAT_OK;
				ptr_d        = head_q;
				rem_d        = count_q;
				state_d      = ST_RESULT;
				case (cmd_q)
					CMD_APPEND: begin
						if (count_q == '0) begin
							ram_we  = 1'b1;
							count_d = CNT_W'(1);
						end else if (full) begin
							res_status_d = STAT_OVERFLOW;
						end else begin
							ram_we    = 1'b1;
							ram_waddr = next_idx(tail_q);
							tail_d    = next_idx(tail_q);
							count_d   = count_q + 1'b1;
						end
					end
					CMD_REMOVE: begin
						if (count_q == '0) begin
							res_status_d = STAT_EMPTY;
						end else begin
							state_d = ST_POP;
						end
					end
					CMD_FIND: begin
						if (count_q == '0) begin
							res_status_d = STAT_NOT_FOUND;
						end else begin
							state_d = ST_SEARCH;
						end
					end
					default: begin
						// Unused code: leave the queue alone, report ok.
					end
				endcase
			end

			ST_POP: begin
				res_data_d = ram_rdata;
				if (count_q == CNT_W'(1)) begin
					// Head stays put so head and tail still coincide.
					count_d = '0;
				end else begin
					head_d  = next_idx(head_q);
					count_d = count_q - 1'b1;
				end
				state_d = ST_RESULT;
			end

			ST_SEARCH: begin
				// ram_rdata holds the entry at ptr_q; prefetch the one after.
				ram_raddr = ptr_nxt;
				if (ram_rdata == data_q) begin
					res_status_d = STAT_OK;
					if (count_q == CNT_W'(1)) begin
						count_d = '0;
						state_d = ST_RESULT;
					end else if (ptr_q == tail_q) begin
						tail_d  = prev_idx(tail_q);
						count_d = count_q - 1'b1;
						state_d = ST_RESULT;
					end else begin
						state_d = ST_SHIFT;
					end
				end else if (rem_q == CNT_W'(1)) begin
					res_status_d = STAT_NOT_FOUND;
					state_d      = ST_RESULT;
				end else begin
					ptr_d = ptr_nxt;
					rem_d = rem_q - 1'b1;
				end
			end

			ST_SHIFT: begin
				// ram_rdata holds the entry after ptr_q: move it one place up.
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = ram_rdata;
				ram_raddr = next_idx(ptr_nxt);
				ptr_d     = ptr_nxt;
				if (ptr_nxt == tail_q) begin
					tail_d  = prev_idx(tail_q);
					count_d = count_q - 1'b1;
					state_d = ST_RESULT;
				end
			end

			ST_RESULT: begin
				// Hold until the output register can take the result.
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	// Working registers: payload only, no reset needed.
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			cmd_q  <= cmd_t'(req.command);
			data_q <= req.data_in;
		end
		ptr_q        <= ptr_d;
		rem_q        <= rem_d;
		res_data_q   <= res_data_d;
		res_status_q <= res_status_d;
	end

	// Output register: load a finished result, drop it once transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			out_data_q   <= res_data_q;
			out_status_q <= res_status_q;
			out_occ_q    <= count_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.data_out  = out_data_q;
	assign rsp.status    = out_status_q;
	assign rsp.occupancy = out_occ_q;

`ifndef SYNTHESIS
	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_empty_aligned : assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("head and tail apart on an empty queue");

	a_count_step : assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
			((count_q == $past(count_q) + 1'b1) || (count_q + 1'b1 == $past(count_q))))
		else $error("entry count moved by more than one");

	a_idle_holds : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !req_xfer) |=> (state_q == ST_IDLE))
		else $error("sequencer left idle without a command transfer");
`endif

endmodule

FILE: dv/brq_checker.sv
// brq_checker: watches both channels of the byte ring queue, predicts every
// result from its own copy of the queue and compares it field by field.
// Depends on brq_pkg, brq_req_if and brq_rsp_if.
module brq_checker
	import brq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF,
	parameter int unsigned OCC_W = $clog2(DEPTH + 1)
) (
	input  logic        clk,
	input  logic        arst_n,
	brq_req_if          req,
	brq_rsp_if          rsp,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned results_checked,
	output int unsigned overflows,
	output int unsigned empties,
	output int unsigned deletions,
	output int unsigned misses
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]       data_out;
		status_t          status;
		logic [OCC_W-1:0] occupancy;
	} queue_result_t;

	logic [7:0]    held_bytes [$];
	queue_result_t awaited [$];
	int unsigned   n_fail, n_checked, n_ovf, n_empty, n_del, n_miss;

	// Apply one command to the shadow queue and return the result it must give.
	function automatic queue_result_t run_command(input cmd_t c, input logic [7:0] b);
		queue_result_t r;
		int            hit;
		r.data_out  = '0;
		r.status    = STAT_OK;
		r.occupancy = '0;
		hit         = -1;
		case (c)
			CMD_APPEND: begin
				if (held_bytes.size() >= DEPTH) r.status = STAT_OVERFLOW;
				else held_bytes.push_back(b);
			end
			CMD_REMOVE: begin
				if (held_bytes.size() == 0) r.status = STAT_EMPTY;
				else r.data_out = held_bytes.pop_front();
			end
			CMD_FIND: begin
				for (int i = 0; i < held_bytes.size(); i++)
					if (hit < 0 && held_bytes[i] == b) hit = i;
				if (hit >= 0) held_bytes.delete(hit);
				else r.status = STAT_NOT_FOUND;
			end
			default: ;
		endcase
		r.occupancy = OCC_W'(held_bytes.size());
		return r;
	endfunction

	task automatic report(input string field, input int unsigned exp, input int unsigned act);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp, act);
		n_fail++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		queue_result_t exp;
		if (!arst_n) begin
			held_bytes.delete();
			awaited.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (awaited.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %02h/%0d/%0d",
						$time, rsp.data_out, rsp.status, rsp.occupancy);
					n_fail++;
				end else begin
					exp = awaited.pop_front();
					n_checked++;
					if (rsp.data_out !== exp.data_out)
						report("data_out", exp.data_out, rsp.data_out);
					if (rsp.status !== exp.status)
						report("status", exp.status, rsp.status);
					if (rsp.occupancy !== exp.occupancy)
						report("occupancy", exp.occupancy, rsp.occupancy);
					case (exp.status)
						STAT_OVERFLOW:  n_ovf++;
						STAT_EMPTY:     n_empty++;
						STAT_NOT_FOUND: n_miss++;
						default:        ;
					endcase
				end
			end
			if (req.valid && req.ready) begin
				exp = run_command(cmd_t'(req.command), req.data_in);
				if (cmd_t'(req.command) == CMD_FIND && exp.status == STAT_OK) n_del++;
				awaited.push_back(exp);
			end
		end
		fail_count      <= n_fail;
		pending         <= awaited.size();
		results_checked <= n_checked;
		overflows       <= n_ovf;
		empties         <= n_empty;
		deletions       <= n_del;
		misses          <= n_miss;
	end

endmodule

FILE: dv/tb_byte_ring_queue_with_delete_core.sv
// tb_byte_ring_queue_with_delete_core: drives commands into the byte ring queue
// and pulls results out under varied idling, then reports the verdict.
// Depends on brq_pkg, brq_req_if, brq_rsp_if, brq_checker and the core.
module tb_byte_ring_queue_with_delete_core
	import brq_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH           = DEPTH_DEF;
	localparam int unsigned OCC_W           = $clog2(DEPTH + 1);
	localparam int unsigned HOLDOFF_CYCLES  = 300;
	localparam int unsigned ITEMS_PER_PHASE = 112;
	localparam int unsigned TAIL_CYCLES     = 2 * DEPTH + 8;
	localparam int unsigned CYCLE_LIMIT     = 400000;

	// Flavour of a stretch of random commands: which way the fill level drifts.
	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_DRAIN,
		MIX_SEARCH,
		MIX_BALANCED
	} mix_t;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned holdoff_asked;
	int unsigned items_sent;
	int unsigned cycle_count;

	int unsigned fail_count, pending, results_checked;
	int unsigned overflows, empties, deletions, misses;

	brq_req_if                   req_ch ();
	brq_rsp_if #(.OCC_W(OCC_W))  rsp_ch ();

	byte_ring_queue_with_delete_core #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	brq_checker #(
		.DEPTH(DEPTH),
		.OCC_W(OCC_W)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.fail_count     (fail_count),
		.pending        (pending),
		.results_checked(results_checked),
		.overflows      (overflows),
		.empties        (empties),
		.deletions      (deletions),
		.misses         (misses)
	);

	// 8 ns clock, high then low.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Offer one command, idling first at the current rate, and hold it until the
	// transfer happens. Valid stays high on return so back-to-back commands
	// never see it dropped and raised in the same step.
	task automatic offer(input cmd_t c, input logic [7:0] d);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.command <= c;
		req_ch.data_in <= d;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	// Stop offering and hold until every awaited result has been taken. The
	// checker's count is registered, hence the first step before looking.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Result side: stall at the phase's rate, or hold ready low for a long
	// stretch whenever the stimulus asks for a hold-off.
	initial begin
		int unsigned holdoff_served;
		int unsigned holdoff_left;
		holdoff_served = 0;
		holdoff_left   = 0;
		rsp_ch.ready  <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_left != 0) begin
				rsp_ch.ready <= 1'b0;
				holdoff_left--;
			end else if (holdoff_served != holdoff_asked) begin
				holdoff_served++;
				holdoff_left  = HOLDOFF_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Watchdog: give up well past the slowest correct run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d results outstanding", cycle_count, pending);
		$display("Verification failed");
		$finish;
	end

	initial begin
		int unsigned seg_left;
		int unsigned lim_append;
		int unsigned lim_remove;
		int unsigned roll;
		logic [7:0]  seg_base;
		logic [7:0]  d;
		cmd_t        c;
		mix_t        mix;

		arst_n         <= 1'b0;
		req_ch.valid   <= 1'b0;
		req_ch.command <= CMD_APPEND;
		req_ch.data_in <= '0;
		stall_pct      <= 0;
		holdoff_asked  <= 0;
		idle_pct        = 0;
		items_sent      = 0;
		seg_left        = 0;
		lim_append      = 0;
		lim_remove      = 0;
		seg_base        = '0;

		// Hold reset, then release it away from the rising edge.
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// Directed: commands on an empty queue, including the unused code.
		offer(CMD_REMOVE, 8'h00);
		offer(CMD_FIND,   8'h5A);
		offer(CMD_NONE,   8'hC3);
		// Delete the only entry by search, then remove the only entry.
		offer(CMD_APPEND, 8'hFF);
		offer(CMD_FIND,   8'hFF);
		offer(CMD_APPEND, 8'h00);
		offer(CMD_REMOVE, 8'hFF);
		// Fill to the brim with 00, 11 .. FF, then push one too many.
		for (int i = 0; i < DEPTH; i++) offer(CMD_APPEND, 8'(i * 17));
		offer(CMD_APPEND, 8'hA5);
		// Delete from the middle of a full queue, miss a search, pop the head.
		offer(CMD_FIND,   8'h77);
		offer(CMD_FIND,   8'h12);
		offer(CMD_REMOVE, 8'h3C);
		drain();

		// Random: four idling phases, each built of stretches that push the fill
		// level up or down so both full and empty queues come round often.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					idle_pct   = 0;
					stall_pct <= 0;
				end
				1: begin
					idle_pct   = 85;
					stall_pct <= 0;
				end
				2: begin
					idle_pct   = 0;
					stall_pct <= 85;
				end
				default: begin
					idle_pct   = 25;
					stall_pct <= 25;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (seg_left == 0) begin
					mix      = mix_t'(2'($urandom_range(3)));
					seg_base = 8'($urandom_range(255));
					seg_left = $urandom_range(40, 8);
					case (mix)
						MIX_FILL: begin
							lim_append = 70;
							lim_remove = 85;
						end
						MIX_DRAIN: begin
							lim_append = 20;
							lim_remove = 75;
						end
						MIX_SEARCH: begin
							lim_append = 35;
							lim_remove = 50;
						end
						default: begin
							lim_append = 40;
							lim_remove = 70;
						end
					endcase
				end
				seg_left--;

				// Starve the result side while commands keep coming, so the core
				// backs up and stalls its input.
				if ((p == 0 && n == 30) || (p == 3 && n == 60))
					holdoff_asked <= holdoff_asked + 1;

				roll = $urandom_range(99);
				if (roll < lim_append)      c = CMD_APPEND;
				else if (roll < lim_remove) c = CMD_REMOVE;
				else if (roll < 97)         c = CMD_FIND;
				else                        c = CMD_NONE;

				// Mostly a narrow band of values, so searches hit and duplicates
				// appear; sometimes any byte at all.
				if ($urandom_range(3) != 0) d = seg_base ^ 8'($urandom_range(3));
				else d = 8'($urandom_range(255));

				offer(c, d);
			end
			drain();
		end

		// Allow any late or stray result to show up before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d commands (directed, then four idling phases with two long hold-offs)",
			items_sent);
		$display("Checked %0d results: %0d overflow, %0d empty, %0d deleted, %0d not found",
			results_checked, overflows, empties, deletions, misses);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
